// ----- hw/rtl/mbpe_pkg.sv -----
// Shared constants and types of the mono bitmap pixel expander.
package mbpe_pkg;

   localparam int SCREEN_WIDTH  = 96;
   localparam int SCREEN_HEIGHT = 64;

   localparam int BYTE_W  = 8;
   localparam int PX_X_W  = 7;
   localparam int PX_Y_W  = 6;
   localparam int COLOR_W = 16;
   localparam int ORG_W   = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INK_COLOR = 2'd2;

   // One data word ready for expansion: lane k of mask is column base + k.
   typedef struct packed {
      logic [BYTE_W-1:0]  mask;
      logic [PX_X_W-1:0]  x_base;
      logic [PX_Y_W-1:0]  y;
      logic [COLOR_W-1:0] color;
   } entry_type;

endpackage

// ----- hw/rtl/mbpe_if.sv -----
// Channel interfaces of the mono bitmap pixel expander.
interface mbpe_req_if;
   logic                          valid;
   logic                          ready;
   logic [mbpe_pkg::BYTE_W-1:0]   pict_byte;
   logic                          first_byte;

   modport source (output valid, output pict_byte, output first_byte, input ready);
   modport sink   (input valid, input pict_byte, input first_byte, output ready);
endinterface

interface mbpe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mbpe_pkg::PX_X_W-1:0]   pixel_x;
   logic [mbpe_pkg::PX_Y_W-1:0]   pixel_y;
   logic [mbpe_pkg::COLOR_W-1:0]  pixel_color;
   logic                          run_last;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                   output run_last, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                   input run_last, output ready);
endinterface

// ----- hw/rtl/mbpe_queue.sv -----
// Two-entry queue between the byte parser and the pixel emitter.
module mbpe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  mbpe_pkg::entry_type push_data,
   output logic                push_ready,
   output logic                pop_valid,
   output mbpe_pkg::entry_type pop_data,
   input  logic                pop_ready
);
   import mbpe_pkg::*;

   entry_type   slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/mbpe_front.sv -----
// Byte parser: walks the header and rows, turns each data word into a pixel mask.
module mbpe_front (
   input  logic                                clock,
   input  logic                                reset,
   mbpe_req_if.sink                            req_if,
   input  logic [mbpe_pkg::ORG_W-1:0]          origin_x,
   input  logic [mbpe_pkg::ORG_W-1:0]          origin_y,
   input  logic [mbpe_pkg::COLOR_W-1:0]        ink_color,
   output logic                                push_valid,
   output mbpe_pkg::entry_type                 push_data,
   input  logic                                push_ready
);
   import mbpe_pkg::*;

   localparam logic [2:0] HDR_IDLE   = 3'd0;
   localparam logic [2:0] HDR_W_LO   = 3'd1;
   localparam logic [2:0] HDR_W_HI   = 3'd2;
   localparam logic [2:0] HDR_H_LO   = 3'd3;
   localparam logic [2:0] HDR_H_HI   = 3'd4;
   localparam logic [2:0] HDR_DATA   = 3'd5;

   localparam logic signed [17:0] SCR_W = 18'(SCREEN_WIDTH);
   localparam logic signed [17:0] SCR_H = 18'(SCREEN_HEIGHT);

   logic [2:0]   header_pos_ff, header_pos_in;
   logic [15:0]  pic_width_ff, pic_width_in;
   logic [15:0]  pic_height_ff, pic_height_in;
   logic [15:0]  row_count_ff, row_count_in;
   logic [12:0]  byte_in_row_ff, byte_in_row_in;
   logic         picture_done_ff, picture_done_in;

   logic                accept;
   logic                drawing;
   logic [15:0]         base_col;
   logic signed [17:0]  x_base;
   logic signed [17:0]  y_pos;
   logic                y_ok;
   logic [7:0]          lane_ok;
   logic [16:0]         col_k;
   logic signed [17:0]  x_k;
   logic [13:0]         bytes_per_row;
   logic [13:0]         next_byte;
   logic [15:0]         next_row;
   logic [15:0]         new_height;

   assign req_if.ready = push_ready;
   assign accept  = req_if.valid && req_if.ready;
   assign drawing = (header_pos_ff == HDR_DATA) && !picture_done_ff && !req_if.first_byte;

   assign base_col = {byte_in_row_ff, 3'b000};
   assign x_base   = {{7{origin_x[ORG_W-1]}}, origin_x} + $signed({2'b00, base_col});
   assign y_pos    = {{7{origin_y[ORG_W-1]}}, origin_y} + $signed({2'b00, row_count_ff});
   assign y_ok     = !y_pos[17] && (y_pos < SCR_H);

   // Lane k is column base_col + k, taken from bit 7-k of the byte.
   always_comb begin
      lane_ok = '0;
      col_k   = '0;
      x_k     = '0;
      for (int k = 0; k < 8; k++) begin
         col_k = {1'b0, base_col} + 17'(k);
         x_k   = x_base + 18'(k);
         lane_ok[k] = req_if.pict_byte[7-k] && (col_k < {1'b0, pic_width_ff}) &&
                      !x_k[17] && (x_k < SCR_W) && y_ok;
      end
   end

   assign push_valid       = accept && drawing && (lane_ok != '0);
   assign push_data.mask   = lane_ok;
   assign push_data.x_base = x_base[PX_X_W-1:0];
   assign push_data.y      = y_pos[PX_Y_W-1:0];
   assign push_data.color  = ink_color;

   assign bytes_per_row = 14'(({1'b0, pic_width_ff} + 17'd7) >> 3);
   assign next_byte     = {1'b0, byte_in_row_ff} + 14'd1;
   assign next_row      = row_count_ff + 16'd1;
   assign new_height    = {req_if.pict_byte, pic_height_ff[7:0]};

   always_comb begin
      header_pos_in   = header_pos_ff;
      pic_width_in    = pic_width_ff;
      pic_height_in   = pic_height_ff;
      row_count_in    = row_count_ff;
      byte_in_row_in  = byte_in_row_ff;
      picture_done_in = picture_done_ff;
      if (accept) begin
         if (req_if.first_byte) begin
            header_pos_in   = HDR_W_LO;
            pic_width_in    = '0;
            pic_height_in   = '0;
            row_count_in    = '0;
            byte_in_row_in  = '0;
            picture_done_in = 1'b0;
         end else begin
            case (header_pos_ff)
               HDR_W_LO: begin
                  pic_width_in  = {pic_width_ff[15:8], req_if.pict_byte};
                  header_pos_in = HDR_W_HI;
               end
               HDR_W_HI: begin
                  pic_width_in  = {req_if.pict_byte, pic_width_ff[7:0]};
                  header_pos_in = HDR_H_LO;
               end
               HDR_H_LO: begin
                  pic_height_in = {pic_height_ff[15:8], req_if.pict_byte};
                  header_pos_in = HDR_H_HI;
               end
               HDR_H_HI: begin
                  pic_height_in   = new_height;
                  header_pos_in   = HDR_DATA;
                  row_count_in    = '0;
                  byte_in_row_in  = '0;
                  picture_done_in = (pic_width_ff == '0) || (new_height == '0);
               end
               HDR_DATA: begin
                  if (!picture_done_ff) begin
                     // Advance to the next row when this word ends the current one.
                     if (next_byte >= bytes_per_row) begin
                        byte_in_row_in = '0;
                        row_count_in   = next_row;
                        if (next_row >= pic_height_ff) begin
                           picture_done_in = 1'b1;
                        end
                     end else begin
                        byte_in_row_in = next_byte[12:0];
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pos_ff   <= HDR_IDLE;
         pic_width_ff    <= '0;
         pic_height_ff   <= '0;
         row_count_ff    <= '0;
         byte_in_row_ff  <= '0;
         picture_done_ff <= 1'b1;
      end else begin
         header_pos_ff   <= header_pos_in;
         pic_width_ff    <= pic_width_in;
         pic_height_ff   <= pic_height_in;
         row_count_ff    <= row_count_in;
         byte_in_row_ff  <= byte_in_row_in;
         picture_done_ff <= picture_done_in;
      end
   end

endmodule

// ----- hw/rtl/mbpe_back.sv -----
// Pixel emitter: sends one pixel write per cycle from the queued lane masks while rsp_if.ready is high.
module mbpe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  mbpe_pkg::entry_type pop_data,
   output logic                pop_ready,
   mbpe_rsp_if.source          rsp_if
);
   import mbpe_pkg::*;

   entry_type   cur_ff, cur_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [2:0]  pick;
   logic [7:0]  remain;
   logic        last;
   logic        sent;

   // Leftmost pending lane first.
   always_comb begin
      pick = '0;
      for (int i = 7; i >= 0; i--) begin
         if (cur_ff.mask[i]) begin
            pick = 3'(i);
         end
      end
   end

   assign remain = cur_ff.mask & ~(8'b1 << pick);
   assign last   = (remain == '0);
   assign sent   = cur_valid_ff && rsp_if.ready;

   assign rsp_if.valid       = cur_valid_ff;
   assign rsp_if.pixel_x     = cur_ff.x_base + PX_X_W'(pick);
   assign rsp_if.pixel_y     = cur_ff.y;
   assign rsp_if.pixel_color = cur_ff.color;
   assign rsp_if.run_last    = last;

   assign pop_ready = !cur_valid_ff || (sent && last);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      if (pop_ready) begin
         cur_in       = pop_data;
         cur_valid_in = pop_valid;
      end else if (sent) begin
         cur_in.mask = remain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ----- hw/rtl/mono_bitmap_pixel_expander.sv -----
// Mono bitmap pixel expander: a 1-bit picture byte stream in, screen pixel writes out.
// The parser takes one byte per cycle as long as the two-entry queue has room; header
// bytes and words that draw nothing produce no output. The emitter drains the queue at
// one pixel write per cycle while rsp_if.ready is high; a data word yields as many
// pixel writes as it has visible set pixels (0 to 8), so the rate under load is set
// by the emitter. The queue lets a new byte be taken while earlier pixels still wait.
// Configuration (origin_x, origin_y, ink_color) is written through the csr_ port.
module mono_bitmap_pixel_expander (
   input  logic                              clock,
   input  logic                              reset,
   mbpe_req_if.sink                          req_if,
   mbpe_rsp_if.source                        rsp_if,
   input  logic                              csr_wr_en,
   input  logic [mbpe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbpe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mbpe_pkg::*;

   logic [ORG_W-1:0]    origin_x_ff;
   logic [ORG_W-1:0]    origin_y_ff;
   logic [COLOR_W-1:0]  ink_color_ff;

   logic        push_valid, push_ready;
   entry_type   push_data;
   logic        pop_valid, pop_ready;
   entry_type   pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         ink_color_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ORIGIN_X:  origin_x_ff  <= csr_wdata[ORG_W-1:0];
            CSR_ORIGIN_Y:  origin_y_ff  <= csr_wdata[ORG_W-1:0];
            CSR_INK_COLOR: ink_color_ff <= csr_wdata[COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mbpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .ink_color  (ink_color_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   mbpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   mbpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule
